/* design/ddasc_pkg.sv */
package ddasc_pkg;

	// Number of decimal digits in each operand and in each result.
	localparam int NUM_DIGITS = 40;
	// Load counter holds 0..NUM_DIGITS, digit index holds 0..NUM_DIGITS-1.
	localparam int CNT_W = $clog2(NUM_DIGITS + 1);
	localparam int IDX_W = $clog2(NUM_DIGITS);

	localparam logic [3:0] DIGIT_MAX = 4'd9;
	localparam logic [4:0] RADIX = 5'd10;

	// Stream widths: input op + two digits padded to bytes, output one digit.
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 8;
	localparam int OUT_USER_W = 5;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_SUB = 1'b1
	} op_t;

	// Operand relation and status, fixed once the last pair is loaded.
	typedef struct packed {
		logic under;
		logic less;
		logic equal;
		logic greater;
		logic zero;
	} flags_t;

	// One queued operation: which digit bank it uses and how many pairs it holds.
	typedef struct packed {
		op_t op;
		logic bank;
		logic [CNT_W-1:0] count;
		flags_t flags;
	} desc_t;

	// Digit pair write from the front end into the operand memory.
	typedef struct packed {
		logic en;
		logic bank;
		logic [IDX_W-1:0] idx;
		logic [3:0] a;
		logic [3:0] b;
	} mem_wr_t;

	// The back end has read the last digit of a bank, which may be reloaded.
	typedef struct packed {
		logic en;
		logic bank;
	} release_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	// Digit codes above nine count as nine.
	function automatic logic [3:0] clamp_digit(input logic [3:0] d);
		clamp_digit = (d > DIGIT_MAX) ? DIGIT_MAX : d;
	endfunction

endpackage

/* design/decimal_digit_add_sub_compare_core.sv */
// Decimal add, subtract and compare on two unsigned NUM_DIGITS-digit numbers.
// Input stream (s_*): one request per digit pair, least significant first;
// s_tdata carries op, digit_a and digit_b, s_tlast marks the most significant
// pair and starts the operation (op is taken from that request). Digits above
// nine count as nine, pairs beyond NUM_DIGITS are dropped, and positions not
// loaded before the last pair count as zero.
// Output stream (m_*): NUM_DIGITS result requests, least significant digit
// first, m_tlast on the most significant one; m_tuser repeats the underflow
// and compare flags on every request.
// Timing: while s_tready is high the front end takes one pair per cycle into
// one of two operand banks. After the last pair the operation passes the queue,
// the memory read stage and the output register; then, while the receiver is
// ready, one digit per cycle follows, NUM_DIGITS in all, read through the single
// read port of the operand memory. The second bank lets the next operation load
// while the current one drains; a third waits until the older bank is read out.
// Reset clears all control state; no operation is pending afterward. When the
// receiver stalls, the output register holds its digit, the back end stops
// reading, and once both banks are in use s_tready drops.
module decimal_digit_add_sub_compare_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [0] op, [4:1] digit_a, [8:5] digit_b, [15:9] zero
	input  logic [ddasc_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [3:0] result_digit, [7:4] zero
	output logic [ddasc_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                 m_tlast,
	// [0] underflow, [1] first_less, [2] first_equal, [3] first_greater,
	// [4] first_is_zero
	output logic [ddasc_pkg::OUT_USER_W-1:0]     m_tuser
);

	logic                 push;
	ddasc_pkg::desc_t     push_data;
	logic                 q_full;
	logic                 q_pop;
	ddasc_pkg::desc_t     q_data;
	logic                 q_empty;
	ddasc_pkg::mem_wr_t   mem_wr;
	ddasc_pkg::release_t  rel;

	// Loading and classification of digit pairs.
	ddasc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full),
		.mem_wr    (mem_wr),
		.rel       (rel)
	);

	// Pending operations between the two halves.
	ddasc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	// Digit-serial arithmetic and result stream.
	ddasc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_data   (q_data),
		.mem_wr   (mem_wr),
		.rel      (rel),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

/* design/ddasc_queue.sv */
module ddasc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ddasc_pkg::desc_t  push_data,
	output logic              full,
	input  logic              pop,
	output ddasc_pkg::desc_t  pop_data,
	output logic              empty
);

	ddasc_pkg::desc_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	// Pointer and fill bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			priority if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + 2'd1;
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* design/ddasc_front.sv */
module ddasc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ddasc_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                                s_tlast,
	output logic                                push,
	output ddasc_pkg::desc_t                    push_data,
	input  logic                                q_full,
	output ddasc_pkg::mem_wr_t                  mem_wr,
	input  ddasc_pkg::release_t                 rel
);

	logic [ddasc_pkg::CNT_W-1:0] load_count_q;
	logic                        wr_bank_q;
	logic [1:0]                  busy_q;
	logic                        less_q;
	logic                        greater_q;
	logic                        nonzero_q;

	logic                        accept;
	logic                        room;
	ddasc_pkg::op_t              op_in;
	logic [3:0]                  da;
	logic [3:0]                  db;
	logic [ddasc_pkg::CNT_W-1:0] count_n;
	logic                        less_n;
	logic                        greater_n;
	logic                        nonzero_n;
	logic [1:0]                  busy_n;

	// A bank may be loaded only after the back end has finished reading it.
	assign s_tready = !busy_q[wr_bank_q] && !q_full;
	assign accept   = s_tvalid && s_tready;

	assign op_in = ddasc_pkg::op_t'(s_tdata[0]);
	assign da    = ddasc_pkg::clamp_digit(s_tdata[4:1]);
	assign db    = ddasc_pkg::clamp_digit(s_tdata[8:5]);
	assign room  = (load_count_q < ddasc_pkg::CNT_W'(ddasc_pkg::NUM_DIGITS));

	// Running compare: digits arrive least significant first, so a
	// differing pair at a higher position overrides what came before.
	always_comb begin
		less_n    = less_q;
		greater_n = greater_q;
		nonzero_n = nonzero_q;
		count_n   = load_count_q;
		if (room) begin
			count_n = load_count_q + ddasc_pkg::CNT_W'(1);
			if (da != db) begin
				less_n    = (da < db);
				greater_n = !(da < db);
			end
			if (da != 4'd0) begin
				nonzero_n = 1'b1;
			end
		end
	end

	// Digit pair write into the current bank.
	always_comb begin
		mem_wr.en   = accept && room;
		mem_wr.bank = wr_bank_q;
		mem_wr.idx  = load_count_q[ddasc_pkg::IDX_W-1:0];
		mem_wr.a    = da;
		mem_wr.b    = db;
	end

	// The last pair hands the finished operation to the queue.
	always_comb begin
		push                  = accept && s_tlast;
		push_data.op          = op_in;
		push_data.bank        = wr_bank_q;
		push_data.count       = count_n;
		push_data.flags.under = (op_in == ddasc_pkg::OP_SUB) && less_n;
		push_data.flags.less  = less_n;
		push_data.flags.equal = !less_n && !greater_n;
		push_data.flags.greater = greater_n;
		push_data.flags.zero  = !nonzero_n;
	end

	// Bank ownership: released by the back end, claimed by the last pair.
	always_comb begin
		busy_n = busy_q;
		if (rel.en) begin
			busy_n[rel.bank] = 1'b0;
		end
		if (accept && s_tlast) begin
			busy_n[wr_bank_q] = 1'b1;
		end
	end

	// Load state and bank ownership.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			wr_bank_q    <= 1'b0;
			busy_q       <= 2'b00;
			less_q       <= 1'b0;
			greater_q    <= 1'b0;
			nonzero_q    <= 1'b0;
		end else begin
			busy_q <= busy_n;
			if (accept) begin
				if (s_tlast) begin
					load_count_q <= '0;
					less_q       <= 1'b0;
					greater_q    <= 1'b0;
					nonzero_q    <= 1'b0;
					wr_bank_q    <= ~wr_bank_q;
				end else begin
					load_count_q <= count_n;
					less_q       <= less_n;
					greater_q    <= greater_n;
					nonzero_q    <= nonzero_n;
				end
			end
		end
	end

endmodule

/* design/ddasc_back.sv */
module ddasc_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	output logic                                 q_pop,
	input  ddasc_pkg::desc_t                     q_data,
	input  ddasc_pkg::mem_wr_t                   mem_wr,
	output ddasc_pkg::release_t                  rel,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ddasc_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                 m_tlast,
	output logic [ddasc_pkg::OUT_USER_W-1:0]     m_tuser
);

	typedef struct packed {
		ddasc_pkg::op_t    op;
		ddasc_pkg::flags_t flags;
		logic              first;
		logic              final_pos;
		logic              blank;
	} s1_ctl_t;

	// Operand memory: two banks, one digit pair per entry.
	logic [7:0]                  mem_q [2][ddasc_pkg::NUM_DIGITS];

	ddasc_pkg::back_state_t      state_q;
	ddasc_pkg::back_state_t      state_n;
	ddasc_pkg::desc_t            desc_q;
	logic [ddasc_pkg::IDX_W-1:0] idx_q;
	logic                        is_final_idx;

	logic                        valid_s1;
	logic [3:0]                  rd_a_s1;
	logic [3:0]                  rd_b_s1;
	s1_ctl_t                     ctl_s1;

	logic                        out_valid_q;
	logic [3:0]                  digit_q;
	logic                        final_q;
	ddasc_pkg::flags_t           flags_q;
	logic                        carry_q;

	logic                        out_free;
	logic                        adv;
	logic                        issue;
	logic [3:0]                  a_eff;
	logic [3:0]                  b_eff;
	logic [4:0]                  cin;
	logic [4:0]                  sum;
	logic [4:0]                  diff;
	logic [3:0]                  res_digit;
	logic                        carry_out;

	assign out_free     = !out_valid_q || m_tready;
	assign adv          = valid_s1 && out_free;
	assign issue        = (state_q == ddasc_pkg::BK_RUN) && (!valid_s1 || out_free);
	assign is_final_idx = (idx_q == ddasc_pkg::IDX_W'(ddasc_pkg::NUM_DIGITS - 1));

	// Sequencer: take one operation, then walk its digit positions.
	always_comb begin
		state_n  = state_q;
		q_pop    = 1'b0;
		rel.en   = 1'b0;
		rel.bank = desc_q.bank;
		unique case (state_q)
			ddasc_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_n = ddasc_pkg::BK_RUN;
				end
			end
			ddasc_pkg::BK_RUN: begin
				if (issue && is_final_idx) begin
					rel.en  = 1'b1;
					state_n = ddasc_pkg::BK_IDLE;
				end
			end
			default: begin
				state_n = ddasc_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddasc_pkg::BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Operation descriptor and position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (q_pop) begin
			idx_q <= '0;
		end else if (issue) begin
			idx_q <= idx_q + ddasc_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			desc_q <= q_data;
		end
	end

	// Memory write from the front end, registered read for the sequencer.
	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem_q[mem_wr.bank][mem_wr.idx] <= {mem_wr.a, mem_wr.b};
		end
		if (issue) begin
			{rd_a_s1, rd_b_s1} <= mem_q[desc_q.bank][idx_q];
		end
	end

	// Read stage control, moving along with the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ctl_s1.op        <= desc_q.op;
			ctl_s1.flags     <= desc_q.flags;
			ctl_s1.first     <= (idx_q == '0);
			ctl_s1.final_pos <= is_final_idx;
			ctl_s1.blank     <= (ddasc_pkg::CNT_W'(idx_q) >= desc_q.count);
		end
	end

	// One decimal digit with carry or borrow; positions never loaded are zero, and an underflow gives zero.
	always_comb begin
		a_eff     = ctl_s1.blank ? 4'd0 : rd_a_s1;
		b_eff     = ctl_s1.blank ? 4'd0 : rd_b_s1;
		cin       = {4'd0, (ctl_s1.first ? 1'b0 : carry_q)};
		sum       = {1'b0, a_eff} + {1'b0, b_eff} + cin;
		diff      = {1'b0, a_eff} + ddasc_pkg::RADIX - cin - {1'b0, b_eff};
		res_digit = 4'd0;
		carry_out = 1'b0;
		unique case (ctl_s1.op)
			ddasc_pkg::OP_ADD: begin
				carry_out = (sum >= ddasc_pkg::RADIX);
				res_digit = carry_out ? 4'(sum - ddasc_pkg::RADIX) : sum[3:0];
			end
			ddasc_pkg::OP_SUB: begin
				carry_out = (diff < ddasc_pkg::RADIX);
				res_digit = carry_out ? diff[3:0] : 4'(diff - ddasc_pkg::RADIX);
			end
			default: begin
				carry_out = 1'b0;
				res_digit = 4'd0;
			end
		endcase
		if (ctl_s1.flags.under) begin
			res_digit = 4'd0;
		end
	end

	// Output register; holds while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			digit_q <= res_digit;
			final_q <= ctl_s1.final_pos;
			flags_q <= ctl_s1.flags;
			carry_q <= carry_out;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(ddasc_pkg::OUT_DATA_W - 4)'(0), digit_q};
	assign m_tlast  = final_q;
	assign m_tuser  = {flags_q.zero, flags_q.greater, flags_q.equal,
			flags_q.less, flags_q.under};

endmodule

/* design/ddasc_checker.sv */
module ddasc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic [ddasc_pkg::IN_DATA_W-1:0]      s_tdata,
	input logic                                 s_tlast,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [ddasc_pkg::OUT_DATA_W-1:0]     m_tdata,
	input logic                                 m_tlast,
	input logic [ddasc_pkg::OUT_USER_W-1:0]     m_tuser
);

	// A stalled result request keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result request changed while stalled");

	// Exactly one of less, equal and greater holds.
	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot(m_tuser[3:1]))
		else $error("compare flags not one-hot");

	// Underflow only with first less, and then the digit is zero.
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[1] && (m_tdata[3:0] == 4'd0))
		else $error("underflow with wrong flags or nonzero digit");

	// Result digits are decimal and padding is zero.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:0] <= ddasc_pkg::DIGIT_MAX) && (m_tdata[7:4] == 4'd0))
		else $error("result digit out of range");

	// Flags stay the same across the digits of one result.
	a_flags_steady: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast ##1 m_tvalid |-> m_tuser == $past(m_tuser))
		else $error("flags changed within one result");

endmodule

bind decimal_digit_add_sub_compare_core ddasc_checker u_ddasc_checker (.*);

/* dv/decimal_digit_add_sub_compare_core_tb.sv */
module decimal_digit_add_sub_compare_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_PAIRS = 215;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = ddasc_pkg::NUM_DIGITS + 16;
	localparam int SHOWN_LIMIT = 10;

	// How the random digits of one operand are drawn.
	typedef enum int {
		DS_ANY,
		DS_RAW,
		DS_NINES,
		DS_ZEROS
	} digit_style_t;

	// One result digit with its flags, as the core should return it.
	typedef struct packed {
		logic [3:0] digit;
		logic       top_digit;
		logic       under;
		logic       less;
		logic       equal;
		logic       greater;
		logic       zero;
	} digit_result_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [ddasc_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                             s_tlast;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [ddasc_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                             m_tlast;
	logic [ddasc_pkg::OUT_USER_W-1:0] m_tuser;

	// Expected result digits, oldest first, and the predictor's operand copies.
	digit_result_t pending_digits[$];
	logic [3:0]    first_digits [ddasc_pkg::NUM_DIGITS];
	logic [3:0]    second_digits [ddasc_pkg::NUM_DIGITS];
	int            pairs_loaded = 0;

	int          burst_left = 0;
	int          fail_count = 0;
	int          shown_count = 0;
	int unsigned cycle_count = 0;
	int          rx_mode = 0;

	decimal_digit_add_sub_compare_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Digit codes above nine are worth nine.
	function automatic logic [3:0] sat_digit(input logic [3:0] d);
		return (d > ddasc_pkg::DIGIT_MAX) ? ddasc_pkg::DIGIT_MAX : d;
	endfunction

	function automatic logic [3:0] pick_digit(input digit_style_t style);
		case (style)
			DS_RAW: return 4'($urandom_range(0, 15));
			DS_NINES: return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 9)) :
					ddasc_pkg::DIGIT_MAX;
			DS_ZEROS: return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 9)) : 4'd0;
			default: return 4'($urandom_range(0, 9));
		endcase
	endfunction

	// Loads one digit pair into the predictor; on the last pair it works out
	// the whole decimal result and queues one expectation per digit.
	task automatic predict_pair(input ddasc_pkg::op_t op, input logic [3:0] a,
			input logic [3:0] b, input logic last);
		logic [3:0]    av [ddasc_pkg::NUM_DIGITS];
		logic [3:0]    bv [ddasc_pkg::NUM_DIGITS];
		logic [3:0]    rv [ddasc_pkg::NUM_DIGITS];
		logic          less;
		logic          equal;
		logic          greater;
		logic          zero;
		logic          under;
		int            carry;
		int            value;
		digit_result_t item;

		if (pairs_loaded < ddasc_pkg::NUM_DIGITS) begin
			first_digits[pairs_loaded] = sat_digit(a);
			second_digits[pairs_loaded] = sat_digit(b);
			pairs_loaded++;
		end
		if (!last)
			return;

		// Positions above the last loaded pair count as zero.
		zero = 1'b1;
		for (int i = 0; i < ddasc_pkg::NUM_DIGITS; i++) begin
			av[i] = (i < pairs_loaded) ? first_digits[i] : 4'd0;
			bv[i] = (i < pairs_loaded) ? second_digits[i] : 4'd0;
			if (av[i] != 4'd0)
				zero = 1'b0;
		end
		pairs_loaded = 0;

		// The most significant differing digit decides the relation.
		less = 1'b0;
		equal = 1'b1;
		greater = 1'b0;
		for (int i = ddasc_pkg::NUM_DIGITS - 1; i >= 0; i--) begin
			if (equal && av[i] != bv[i]) begin
				equal = 1'b0;
				less = av[i] < bv[i];
				greater = !less;
			end
		end
		under = (op == ddasc_pkg::OP_SUB) && less;

		// Ripple the carry or borrow up through the digits.
		carry = 0;
		for (int i = 0; i < ddasc_pkg::NUM_DIGITS; i++) begin
			if (op == ddasc_pkg::OP_ADD) begin
				value = int'(av[i]) + int'(bv[i]) + carry;
				carry = (value > 9) ? 1 : 0;
				if (carry != 0)
					value -= 10;
			end else if (under) begin
				value = 0;
			end else begin
				value = int'(av[i]) - int'(bv[i]) - carry;
				carry = (value < 0) ? 1 : 0;
				if (carry != 0)
					value += 10;
			end
			rv[i] = 4'(value);
		end

		for (int i = 0; i < ddasc_pkg::NUM_DIGITS; i++) begin
			item.digit = rv[i];
			item.top_digit = (i == ddasc_pkg::NUM_DIGITS - 1);
			item.under = under;
			item.less = less;
			item.equal = equal;
			item.greater = greater;
			item.zero = zero;
			pending_digits.push_back(item);
		end
	endtask

	// Offers one digit pair and returns at the edge where it is taken. The
	// sender runs in bursts, most of them preceded by an idle gap.
	task automatic send_pair(input ddasc_pkg::op_t op, input logic [3:0] a,
			input logic [3:0] b, input logic last);
		int gap;

		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) :
					$urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {{(ddasc_pkg::IN_DATA_W - 9){1'b0}}, b, a, op};
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		predict_pair(op, a, b, last);
	endtask

	// Operations made of a single pair, including a clamped digit and underflow.
	task automatic test_single_pair_ops();
		send_pair(ddasc_pkg::OP_ADD, 4'd0, 4'd0, 1'b1);
		send_pair(ddasc_pkg::OP_SUB, 4'd15, 4'd0, 1'b1);
		send_pair(ddasc_pkg::OP_SUB, 4'd3, 4'd15, 1'b1);
	endtask

	// Carries that run out of the loaded digits into the zero positions above.
	// The op on the leading pairs is the opposite one and must not matter.
	task automatic test_carry_and_clamp();
		send_pair(ddasc_pkg::OP_SUB, 4'd15, 4'd1, 1'b0);
		send_pair(ddasc_pkg::OP_SUB, 4'd9, 4'd0, 1'b0);
		send_pair(ddasc_pkg::OP_ADD, 4'd9, 4'd0, 1'b1);
		send_pair(ddasc_pkg::OP_SUB, 4'd15, 4'd15, 1'b0);
		send_pair(ddasc_pkg::OP_ADD, 4'd15, 4'd15, 1'b1);
	endtask

	// Subtract with first smaller, equal operands, and a borrow that runs through two digits.
	task automatic test_subtract_cases();
		send_pair(ddasc_pkg::OP_ADD, 4'd5, 4'd0, 1'b0);
		send_pair(ddasc_pkg::OP_SUB, 4'd0, 4'd1, 1'b1);
		send_pair(ddasc_pkg::OP_ADD, 4'd7, 4'd7, 1'b0);
		send_pair(ddasc_pkg::OP_SUB, 4'd3, 4'd3, 1'b1);
		send_pair(ddasc_pkg::OP_ADD, 4'd0, 4'd1, 1'b0);
		send_pair(ddasc_pkg::OP_ADD, 4'd0, 4'd0, 1'b0);
		send_pair(ddasc_pkg::OP_SUB, 4'd1, 4'd0, 1'b1);
	endtask

	// Random operations: full length, short, and longer than the core holds,
	// with digit mixes that favor carry chains, borrow chains and equal operands.
	task automatic test_random_ops();
		int             sent;
		int             len;
		digit_style_t   a_style;
		digit_style_t   b_style;
		logic           mirror;
		ddasc_pkg::op_t op;
		logic [3:0]     a;
		logic [3:0]     b;

		sent = 0;
		while (sent < RANDOM_PAIRS) begin
			case ($urandom_range(0, 9))
				0, 1, 2: len = ddasc_pkg::NUM_DIGITS;
				3: len = ddasc_pkg::NUM_DIGITS + $urandom_range(1, 4);
				4, 5: len = $urandom_range(13, ddasc_pkg::NUM_DIGITS - 1);
				default: len = $urandom_range(1, 12);
			endcase
			// The final operation is cut to the remaining budget.
			if (len > RANDOM_PAIRS - sent)
				len = RANDOM_PAIRS - sent;
			op = ddasc_pkg::op_t'($urandom_range(0, 1));
			a_style = digit_style_t'($urandom_range(0, 3));
			b_style = digit_style_t'($urandom_range(0, 3));
			mirror = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < len; i++) begin
				a = pick_digit(a_style);
				b = (mirror && $urandom_range(0, 15) != 0) ? a : pick_digit(b_style);
				if (i == len - 1)
					send_pair(op, a, b, 1'b1);
				else
					send_pair(ddasc_pkg::op_t'($urandom_range(0, 1)), a, b, 1'b0);
			end
			sent += len;
		end
	endtask

	// Receiver stall pattern: the mode changes every so often between always
	// ready, light random stalls, a fixed rhythm, and heavy stalls.
	always @(posedge clk) begin
		if (cycle_count % 97 == 0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= (cycle_count % 5 != 0);
			default: m_tready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// Check every accepted result digit against the oldest expectation.
	always @(posedge clk) begin : check_results
		digit_result_t got;
		digit_result_t want;
		logic          pad_bad;

		if (arst_n && m_tvalid && m_tready) begin
			got.digit = m_tdata[3:0];
			got.top_digit = m_tlast;
			got.under = m_tuser[0];
			got.less = m_tuser[1];
			got.equal = m_tuser[2];
			got.greater = m_tuser[3];
			got.zero = m_tuser[4];
			pad_bad = (m_tdata[ddasc_pkg::OUT_DATA_W-1:4] != '0);
			if (pending_digits.size() == 0) begin
				fail_count++;
				if (shown_count < SHOWN_LIMIT) begin
					shown_count++;
					$display("unexpected result digit %0d last %b flags %b",
							got.digit, got.top_digit, m_tuser);
				end
			end else begin
				want = pending_digits.pop_front();
				if (got !== want || pad_bad) begin
					fail_count++;
					if (shown_count < SHOWN_LIMIT) begin
						shown_count++;
						$display({"result mismatch: expected digit %0d last %b ",
								"uflt/lt/eq/gt/zero %b%b%b%b%b"},
								want.digit, want.top_digit, want.under, want.less,
								want.equal, want.greater, want.zero);
						$display({"                 got      digit %0d last %b ",
								"uflt/lt/eq/gt/zero %b%b%b%b%b pad %h"},
								got.digit, got.top_digit, got.under, got.less,
								got.equal, got.greater, got.zero,
								m_tdata[ddasc_pkg::OUT_DATA_W-1:4]);
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		m_tready <= 1'b0;
		for (int i = 0; i < ddasc_pkg::NUM_DIGITS; i++) begin
			first_digits[i] = 4'd0;
			second_digits[i] = 4'd0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_pair_ops();
		test_carry_and_clamp();
		test_subtract_cases();
		test_random_ops();
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		// Let the last operation drain, then watch for stray results.
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
design/ddasc_pkg.sv
design/ddasc_queue.sv
design/ddasc_front.sv
design/ddasc_back.sv
design/decimal_digit_add_sub_compare_core.sv
design/ddasc_checker.sv
dv/decimal_digit_add_sub_compare_core_tb.sv
